// ===== rtl/gas_pkg.sv =====
// shared types and constants for the global alignment score block
`default_nettype none
package gas_pkg;

  localparam int SCORE_W = 14;
  localparam int SYM_W   = 8;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [SYM_W-1:0]          sym_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_REF   = 2'd1,
    ACT_QRY   = 2'd2,
    ACT_FIN   = 2'd3
  } action_t;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_LEN  = 2'd1;
  localparam logic [1:0] ERR_LATE = 2'd2;

  localparam score_t SC_MATCH    = 14'sd4;
  localparam score_t SC_MISMATCH = -14'sd2;
  localparam score_t SC_GAP      = -14'sd4;
  localparam score_t SCORE_MIN   = -14'sd8192;
  localparam score_t SCORE_MAX   = 14'sd8191;

  // one wavefront slot moving down the chain
  typedef struct packed {
    logic   valid;
    sym_t   sym;
    score_t h_old;
    score_t h_new;
  } link_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic wr_en;
    logic clr;
    sym_t sym;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/gas_if.sv =====
// request and result channel interfaces
`default_nettype none
interface gas_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink (input valid, input action, input symbol, output ready);
endinterface

interface gas_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] score;
  logic [1:0]         error;

  modport source (output valid, output score, output error, input ready);
  modport sink (input valid, input score, input error, output ready);
endinterface
`default_nettype wire

// ===== rtl/gas_cell.sv =====
// one dp cell: holds a reference byte and its column of the last row
`default_nettype none
module gas_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gas_pkg::cell_ctl_t ctl,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire gas_pkg::link_t    link_i,
  output gas_pkg::link_t         link_o
);

  // first-row value of this column, -4 times its position, saturated
  localparam int INIT_I = (4 * (CELL_IDX + 1) > 8192) ? -8192 : -4 * (CELL_IDX + 1);
  localparam gas_pkg::score_t INIT_H = 14'(INIT_I);

  gas_pkg::sym_t   ref_r;
  gas_pkg::score_t h_r;
  logic            act_r;
  logic            vld_r;
  gas_pkg::sym_t   sym_r;
  gas_pkg::score_t hold_r;
  gas_pkg::score_t hnew_r;

  logic               wr_sel;
  logic signed [14:0] diag;
  logic signed [14:0] up;
  logic signed [14:0] left;
  logic signed [14:0] best;
  gas_pkg::score_t    cell_nxt;

  assign wr_sel = ctl.wr_en && (wr_idx == IDX_W'(CELL_IDX));

  always_comb begin
    diag = 15'(link_i.h_old) + ((ref_r == link_i.sym) ? 15'(gas_pkg::SC_MATCH)
                                                      : 15'(gas_pkg::SC_MISMATCH));
    up   = 15'(h_r) + 15'(gas_pkg::SC_GAP);
    left = 15'(link_i.h_new) + 15'(gas_pkg::SC_GAP);
    best = diag;
    if (up > best) best = up;
    if (left > best) best = left;
    priority if (best < 15'(gas_pkg::SCORE_MIN)) begin
      cell_nxt = gas_pkg::SCORE_MIN;
    end else if (best > 15'(gas_pkg::SCORE_MAX)) begin
      cell_nxt = gas_pkg::SCORE_MAX;
    end else begin
      cell_nxt = best[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      vld_r <= link_i.valid;
      if (ctl.clr) begin
        act_r <= 1'b0;
      end else if (wr_sel) begin
        act_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      ref_r <= ctl.sym;
      h_r   <= INIT_H;
    end else if (link_i.valid && act_r) begin
      h_r <= cell_nxt;
    end
    if (link_i.valid) begin
      sym_r <= link_i.sym;
      // unused columns pass the row end straight through
      if (act_r) begin
        hold_r <= h_r;
        hnew_r <= cell_nxt;
      end else begin
        hold_r <= link_i.h_old;
        hnew_r <= link_i.h_new;
      end
    end
  end

  assign link_o = '{valid: vld_r, sym: sym_r, h_old: hold_r, h_new: hnew_r};

endmodule
`default_nettype wire

// ===== rtl/gas_array.sv =====
// systolic chain of dp cells, one per reference position
`default_nettype none
module gas_array #(
  parameter int NUM_CELLS = 1024,
  parameter int IDX_W     = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gas_pkg::cell_ctl_t ctl,
  input  wire logic [IDX_W-1:0]   wr_idx,
  input  wire gas_pkg::link_t     link_i,
  output gas_pkg::link_t          link_o
);

  gas_pkg::link_t chain [0:NUM_CELLS];

  assign chain[0] = link_i;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gas_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .link_i (chain[i]),
      .link_o (chain[i+1])
    );
  end

  assign link_o = chain[NUM_CELLS];

endmodule
`default_nettype wire

// ===== rtl/global_alignment_score.sv =====
// global alignment score: one request register, a sequencer and the cell chain
// reference and query requests leave the request register without waiting;
// query rows stream into the chain one per cycle while no start or finish waits,
// finish (and start) wait until the last query row has passed the last cell,
// finish also waits for a free output register, where the score is then registered
// synchronous active-low reset clears lengths, error and cell use flags; no memory sweep
`default_nettype none
module global_alignment_score #(
  parameter int MAX_REF_LEN   = 1024,
  parameter int MAX_QUERY_LEN = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gas_in_if.sink      in_if,
  gas_out_if.source   out_if
);

  localparam int IDX_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int RL_W  = $clog2(MAX_REF_LEN + 1);
  localparam int QL_W  = $clog2(MAX_QUERY_LEN + 1);

  logic               pend_valid_r;
  gas_pkg::action_t   pend_act_r;
  gas_pkg::sym_t      pend_sym_r;

  logic [RL_W-1:0]    reflen_r, reflen_nxt;
  logic [QL_W-1:0]    qlen_r, qlen_nxt;
  logic [1:0]         err_r, err_nxt;
  gas_pkg::score_t    head_r, head_nxt;
  logic [IDX_W-1:0]   drain_r, drain_nxt;
  logic               out_valid_r, out_valid_nxt;
  gas_pkg::score_t    out_score_r, out_score_nxt;
  logic [1:0]         out_error_r, out_error_nxt;

  logic               in_fire;
  logic               disp;
  logic               drain_idle;
  logic               out_free;
  gas_pkg::score_t    head_step;
  logic [19:0]        ref_gap;
  gas_pkg::score_t    empty_score;
  gas_pkg::cell_ctl_t ctl;
  gas_pkg::link_t     link_in;
  gas_pkg::link_t     link_out;

  assign drain_idle = (drain_r == '0);
  assign out_free   = !out_valid_r || out_if.ready;

  always_comb begin
    unique case (pend_act_r)
      gas_pkg::ACT_START:                 disp = drain_idle;
      gas_pkg::ACT_REF, gas_pkg::ACT_QRY: disp = 1'b1;
      gas_pkg::ACT_FIN:                   disp = drain_idle && out_free;
      default:                            disp = 1'b0;
    endcase
    disp = disp && pend_valid_r;
  end

  assign in_if.ready = !pend_valid_r || disp;
  assign in_fire     = in_if.valid && in_if.ready;

  // column zero of the next row, saturating
  assign head_step = (head_r < (gas_pkg::SCORE_MIN - gas_pkg::SC_GAP)) ? gas_pkg::SCORE_MIN
                                                                       : head_r + gas_pkg::SC_GAP;

  // score with no query yet: a gap for every reference byte
  assign ref_gap     = 20'(reflen_r) << 2;
  assign empty_score = (ref_gap >= 20'd8192) ? gas_pkg::SCORE_MIN : 14'(0) - ref_gap[13:0];

  always_comb begin
    reflen_nxt    = reflen_r;
    qlen_nxt      = qlen_r;
    err_nxt       = err_r;
    head_nxt      = head_r;
    drain_nxt     = drain_idle ? drain_r : drain_r - 1'b1;
    out_valid_nxt = out_if.ready ? 1'b0 : out_valid_r;
    out_score_nxt = out_score_r;
    out_error_nxt = out_error_r;
    ctl           = '{wr_en: 1'b0, clr: 1'b0, sym: pend_sym_r};
    link_in       = '{valid: 1'b0, sym: pend_sym_r, h_old: head_r, h_new: head_step};
    if (disp) begin
      unique case (pend_act_r)
        gas_pkg::ACT_START: begin
          reflen_nxt = '0;
          qlen_nxt   = '0;
          err_nxt    = gas_pkg::ERR_OK;
          head_nxt   = '0;
          ctl.clr    = 1'b1;
        end
        gas_pkg::ACT_REF: begin
          priority if (qlen_r != '0) begin
            if (err_r == gas_pkg::ERR_OK) err_nxt = gas_pkg::ERR_LATE;
          end else if (reflen_r == RL_W'(MAX_REF_LEN)) begin
            if (err_r == gas_pkg::ERR_OK) err_nxt = gas_pkg::ERR_LEN;
          end else begin
            ctl.wr_en  = 1'b1;
            reflen_nxt = reflen_r + 1'b1;
          end
        end
        gas_pkg::ACT_QRY: begin
          if (qlen_r == QL_W'(MAX_QUERY_LEN)) begin
            if (err_r == gas_pkg::ERR_OK) err_nxt = gas_pkg::ERR_LEN;
          end else begin
            link_in.valid = 1'b1;
            qlen_nxt      = qlen_r + 1'b1;
            head_nxt      = head_step;
            drain_nxt     = IDX_W'(MAX_REF_LEN - 1);
          end
        end
        gas_pkg::ACT_FIN: begin
          out_valid_nxt = 1'b1;
          out_score_nxt = (qlen_r == '0) ? empty_score : link_out.h_new;
          out_error_nxt = err_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      reflen_r     <= '0;
      qlen_r       <= '0;
      err_r        <= gas_pkg::ERR_OK;
      head_r       <= '0;
      drain_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_valid_r <= 1'b1;
      end else if (disp) begin
        pend_valid_r <= 1'b0;
      end
      reflen_r    <= reflen_nxt;
      qlen_r      <= qlen_nxt;
      err_r       <= err_nxt;
      head_r      <= head_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_act_r <= gas_pkg::action_t'(in_if.action);
      pend_sym_r <= in_if.symbol;
    end
    out_score_r <= out_score_nxt;
    out_error_r <= out_error_nxt;
  end

  gas_array #(
    .NUM_CELLS (MAX_REF_LEN),
    .IDX_W     (IDX_W)
  ) u_array (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .wr_idx (reflen_r[IDX_W-1:0]),
    .link_i (link_in),
    .link_o (link_out)
  );

  assign out_if.valid = out_valid_r;
  assign out_if.score = out_score_r;
  assign out_if.error = out_error_r;

endmodule
`default_nettype wire

// ===== rtl/gas_chk.sv =====
// port-level checks for the global alignment score block
`default_nettype none
module gas_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [13:0] out_score,
  input wire logic [1:0]         out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_score) && $stable(out_error))
    else $error("result changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error == 2'd0 || out_error == 2'd1 || out_error == 2'd2))
    else $error("undefined error code on result");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind global_alignment_score gas_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_score (out_if.score),
  .out_error (out_if.error)
);
`default_nettype wire

// ===== tb/sv/global_alignment_score_checker.sv =====
// alignment score checker: mirrors the dp rows from accepted requests and checks every result
module global_alignment_score_checker
  import gas_pkg::*;
#(
  parameter int MAX_REF_LEN   = 1024,
  parameter int MAX_QUERY_LEN = 1024
) (
  input  logic clk,
  input  logic rst_n,
  gas_in_if    req_mon,
  gas_out_if   res_mon,
  output int   mismatches,
  output int   awaiting
);

  typedef struct packed {
    score_t     score;
    logic [1:0] error;
  } outcome_t;

  sym_t       ref_seq [MAX_REF_LEN];
  int         dp_row [MAX_REF_LEN+1];
  int         ref_len  = 0;
  int         qry_len  = 0;
  logic [1:0] err_code = ERR_OK;
  int         fail_tally = 0;
  outcome_t   corner_scores [$];

  function automatic int clip_score(input int v);
    if (v < int'(SCORE_MIN)) return int'(SCORE_MIN);
    if (v > int'(SCORE_MAX)) return int'(SCORE_MAX);
    return v;
  endfunction

  // first error wins until the next start
  function automatic void raise_err(input logic [1:0] code);
    if (err_code == ERR_OK) err_code = code;
  endfunction

  // one query byte turns the stored row into the next one
  function automatic void extend_dp_row(input sym_t q);
    int   diag_src;
    int   left;
    int   above;
    int   best;
    int   x;
    logic fresh;
    fresh    = (qry_len == 0);
    diag_src = fresh ? 0 : dp_row[0];
    left     = clip_score(int'(SC_GAP) * (qry_len + 1));
    dp_row[0] = left;
    for (x = 1; x <= ref_len; x++) begin
      // before any query the row above is the all-gap border
      above = fresh ? clip_score(int'(SC_GAP) * x) : dp_row[x];
      best  = diag_src + ((ref_seq[x-1] == q) ? int'(SC_MATCH) : int'(SC_MISMATCH));
      if (above + int'(SC_GAP) > best) best = above + int'(SC_GAP);
      if (left + int'(SC_GAP) > best) best = left + int'(SC_GAP);
      left      = clip_score(best);
      diag_src  = above;
      dp_row[x] = left;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t due;
    if (rst_n) begin
      if (req_mon.valid && req_mon.ready) begin
        case (action_t'(req_mon.action))
          ACT_START: begin
            ref_len  = 0;
            qry_len  = 0;
            err_code = ERR_OK;
          end
          ACT_REF: begin
            if (qry_len != 0) raise_err(ERR_LATE);
            else if (ref_len >= MAX_REF_LEN) raise_err(ERR_LEN);
            else begin
              ref_seq[ref_len] = req_mon.symbol;
              ref_len++;
            end
          end
          ACT_QRY: begin
            if (qry_len >= MAX_QUERY_LEN) raise_err(ERR_LEN);
            else begin
              extend_dp_row(req_mon.symbol);
              qry_len++;
            end
          end
          ACT_FIN: begin
            if (qry_len == 0) due.score = score_t'(clip_score(int'(SC_GAP) * ref_len));
            else due.score = score_t'(dp_row[ref_len]);
            due.error = err_code;
            corner_scores.push_back(due);
          end
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (corner_scores.size() == 0) begin
          $display("%0t unexpected result: score %0d error %0d", $time,
                   res_mon.score, res_mon.error);
          fail_tally++;
        end else begin
          due = corner_scores.pop_front();
          if (res_mon.score !== due.score) begin
            $display("%0t score: expected %0d, got %0d", $time, due.score, res_mon.score);
            fail_tally++;
          end
          if (res_mon.error !== due.error) begin
            $display("%0t error: expected %0d, got %0d", $time, due.error, res_mon.error);
            fail_tally++;
          end
        end
      end
    end
    mismatches <= fail_tally;
    awaiting   <= corner_scores.size();
  end

endmodule

// ===== tb/sv/global_alignment_score_tb.sv =====
// global alignment score testbench top: clock, reset, request and result traffic, verdict
module global_alignment_score_tb;
  import gas_pkg::*;

  localparam int MAX_REF_LEN   = 1024;
  localparam int MAX_QUERY_LEN = 1024;
  localparam int RANDOM_REQS   = 860;
  localparam int OVERFLOW_REQS = MAX_REF_LEN + 16;
  localparam int TAIL_REQS     = 300;
  localparam int LONG_HOLD     = 2000;
  localparam int CYCLE_LIMIT   = 8000000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   awaiting;
  int   req_total;
  int   gap_odds;
  bit   quiet_tail;
  bit   hold_off_go;

  gas_in_if  req_ch ();
  gas_out_if res_ch ();

  global_alignment_score #(
    .MAX_REF_LEN  (MAX_REF_LEN),
    .MAX_QUERY_LEN(MAX_QUERY_LEN)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (req_ch),
    .out_if(res_ch)
  );

  global_alignment_score_checker #(
    .MAX_REF_LEN  (MAX_REF_LEN),
    .MAX_QUERY_LEN(MAX_QUERY_LEN)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (req_ch),
    .res_mon   (res_ch),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("global_alignment_score: mismatch");
    $finish;
  end

  // result side: stall bursts whose density is redrawn at the start of each span
  initial begin
    int hold_left;
    int odds;
    int span;
    hold_left = 0;
    odds      = 0;
    span      = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = 256;
        case ($urandom_range(0, 2))
          0:       odds = 0;
          1:       odds = 10;
          default: odds = 3;
        endcase
      end
      span--;
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        hold_left   = LONG_HOLD;
      end
      if (hold_left == 0 && !quiet_tail && odds != 0 && $urandom_range(1, odds) == 1)
        hold_left = $urandom_range(1, 17);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input action_t act, input sym_t sym);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.symbol <= sym;
    do @(posedge clk); while (!req_ch.ready);
    req_total++;
  endtask

  // stop offering until every finish has produced its score
  task automatic wait_scores_in();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  function automatic sym_t any_sym();
    return sym_t'($urandom_range(0, 255));
  endfunction

  // narrow alphabets give plenty of matches, spread 255 covers every byte
  function automatic sym_t pick_sym(input sym_t base, input int spread);
    return sym_t'(base + $urandom_range(0, spread));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 49) == 0) send_req(action_t'($urandom_range(0, 3)), any_sym());
  endtask

  task automatic run_alignment(input int n_ref, input int n_qry);
    sym_t base;
    int   spread;
    int   late_at;
    base   = any_sym();
    spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 3);
    case ($urandom_range(0, 2))
      0:       gap_odds = 0;
      1:       gap_odds = 12;
      default: gap_odds = 3;
    endcase
    late_at = (n_qry > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, n_qry - 1) : -1;
    // now and then carry on from the previous alignment without a start
    if ($urandom_range(0, 9) != 0) send_req(ACT_START, any_sym());
    repeat (n_ref) begin
      send_req(ACT_REF, pick_sym(base, spread));
      maybe_noise();
    end
    for (int q = 0; q < n_qry; q++) begin
      if (q == late_at) send_req(ACT_REF, pick_sym(base, spread));
      send_req(ACT_QRY, pick_sym(base, spread));
      maybe_noise();
    end
    send_req(ACT_FIN, any_sym());
    if ($urandom_range(0, 5) == 0) send_req(ACT_FIN, any_sym());
    if ($urandom_range(0, 4) == 0) wait_scores_in();
  endtask

  initial begin
    int trips;
    sym_t base;
    rst_n         <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_START;
    req_ch.symbol <= '0;
    req_total   = 0;
    gap_odds    = 0;
    quiet_tail  = 1'b0;
    hold_off_go = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(ACT_FIN, 8'h00);    // finish straight out of reset
    send_req(ACT_START, 8'hFF);
    send_req(ACT_REF, 8'h00);
    send_req(ACT_REF, 8'hFF);
    send_req(ACT_FIN, 8'h00);    // no query row yet, all-gap score
    send_req(ACT_FIN, 8'hFF);    // repeated finish
    send_req(ACT_QRY, 8'hFF);
    send_req(ACT_QRY, 8'h00);
    send_req(ACT_FIN, 8'h00);
    send_req(ACT_REF, 8'h5A);    // reference byte after the query began
    send_req(ACT_QRY, 8'hFF);
    send_req(ACT_FIN, 8'h00);
    send_req(ACT_START, 8'h00);
    send_req(ACT_QRY, 8'hAA);    // empty reference
    send_req(ACT_FIN, 8'h55);
    send_req(ACT_START, 8'h00);
    send_req(ACT_FIN, 8'h00);    // empty alignment
    wait_scores_in();

    trips = 0;
    while (req_total < RANDOM_REQS + OVERFLOW_REQS) begin
      trips++;
      if (trips == 2) begin
        // receiver holds off while short alignments keep coming
        gap_odds    = 0;
        hold_off_go = 1'b1;
        repeat (12) begin
          send_req(ACT_START, any_sym());
          repeat ($urandom_range(0, 3)) send_req(ACT_REF, any_sym());
          send_req(ACT_FIN, any_sym());
        end
        wait_scores_in();
      end else if (trips == 4) begin
        // reference runs past the bound, rows over the full chain, then a late
        // reference that must not replace the length error
        gap_odds = 12;
        base     = any_sym();
        send_req(ACT_START, any_sym());
        repeat (MAX_REF_LEN + 2) send_req(ACT_REF, pick_sym(base, 3));
        repeat (3) send_req(ACT_QRY, pick_sym(base, 3));
        send_req(ACT_FIN, any_sym());
        send_req(ACT_REF, any_sym());
        send_req(ACT_FIN, any_sym());
      end else begin
        run_alignment(pick_len(), pick_len());
      end
      if (req_total >= RANDOM_REQS + OVERFLOW_REQS - TAIL_REQS) quiet_tail = 1'b1;
    end

    quiet_tail = 1'b1;
    wait_scores_in();
    repeat (MAX_REF_LEN + 16) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("global_alignment_score: match");
    end else begin
      $display("global_alignment_score: mismatch");
    end
    $finish;
  end

endmodule
